// ----- hdl/nfa_sa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nfa_sa_pkg;

   localparam int NUM_STATES     = 16;
   localparam int SYMBOL_BITS    = 8;
   localparam int SYM_COUNT      = 1 << SYMBOL_BITS;
   localparam int STATE_IDX_BITS = $clog2(NUM_STATES);

   // field widths of the ports
   localparam int OPCODE_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int STATE_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [OPCODE_W-1:0]   opcode_type;
   typedef logic [NUM_STATES-1:0] state_set_type;

   localparam opcode_type OP_ADD_TRANS = 2'd0;
   localparam opcode_type OP_SYMBOL    = 2'd1;
   localparam opcode_type OP_END       = 2'd2;
   localparam opcode_type OP_UNUSED    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DEFINED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK   = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/nfa_string_acceptor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Subset simulation of an epsilon-free NFA over byte strings. One item is taken every
// cycle while req_stall is low: add-transition beats set one destination bit in the
// banked transition store, symbol beats read the store row for that symbol from all
// origin banks in one synchronous read and OR the rows of the active states into the
// new active set, and end-of-string beats give one result beat. The store read register
// and the result register form the two stages; a blocked result holds stage one. The
// active-set update in the second stage closes its loop through the active-set register
// alone, so symbols stream back to back. After reset a clearing pass zeroes the store
// one row per cycle, during which req_stall stays high; configuration writes are taken at any time.
module nfa_string_acceptor_top
   import nfa_sa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [SYMBOL_W-1:0]   req_symbol,
   input  wire logic [STATE_W-1:0]    req_from_state,
   input  wire logic [STATE_W-1:0]    req_to_state,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_accepted,
   output      logic                  rsp_status,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [STATE_W-1:0]    start_state_ff;
   logic                  start_defined_ff;
   logic [CSR_DATA_W-1:0] accept_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff   <= '0;
         start_defined_ff <= 1'b0;
         accept_mask_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_STATE:   start_state_ff   <= csr_wdata[STATE_W-1:0];
            CSR_START_DEFINED: start_defined_ff <= csr_wdata[0];
            CSR_ACCEPT_MASK:   accept_mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing pass
   logic                   clr_busy_ff, clr_busy_in;
   logic [SYMBOL_BITS-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SYMBOL_BITS'(SYM_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // stage one: store access
   logic       s1_valid_ff, s1_valid_in;
   opcode_type s1_op_ff;
   logic       s1_adv;
   logic       req_accept;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_accepted_ff, rsp_status_ff;

   logic [SYMBOL_BITS-1:0]    sym_addr;
   logic [STATE_IDX_BITS-1:0] to_idx;
   logic                      add_ok;

   assign s1_adv     = s1_valid_ff && (s1_op_ff != OP_END || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   assign sym_addr = req_symbol[SYMBOL_BITS-1:0];
   assign to_idx   = STATE_IDX_BITS'(req_to_state);
   assign add_ok   = req_accept && req_opcode == OP_ADD_TRANS
                     && 32'(req_to_state) < NUM_STATES;

   state_set_type row_all [NUM_STATES];

   for (genvar b = 0; b < NUM_STATES; b++) begin : g_bank
      state_set_type mem [SYM_COUNT];
      state_set_type row_ff;
      logic          wr_en;

      assign wr_en = add_ok && 32'(req_from_state) == b;

      always_ff @(posedge clock) begin
         if (clr_busy_ff) begin
            mem[clr_addr_ff] <= '0;
         end else if (wr_en) begin
            mem[sym_addr][to_idx] <= 1'b1;
         end
         if (req_accept) begin
            row_ff <= mem[sym_addr];
         end
      end

      assign row_all[b] = row_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_op_ff <= req_opcode;
      end
   end

   // stage two: active set update and result
   state_set_type active_ff, active_in;
   logic          fresh_ff, fresh_in;
   state_set_type start_set;
   state_set_type cur_set;
   state_set_type next_set;
   state_set_type accept_vec;
   logic          res_accepted;

   always_comb begin
      start_set = '0;
      if (start_defined_ff && 32'(start_state_ff) < NUM_STATES) begin
         start_set = state_set_type'(1) << start_state_ff;
      end
   end

   assign cur_set    = fresh_ff ? start_set : active_ff;
   assign accept_vec = state_set_type'(accept_mask_ff);
   assign res_accepted = start_defined_ff && (|(cur_set & accept_vec));

   always_comb begin
      next_set = '0;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (cur_set[s]) begin
            next_set = next_set | row_all[s];
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      fresh_in  = fresh_ff;
      if (s1_adv) begin
         unique case (s1_op_ff)
            OP_SYMBOL: begin
               active_in = next_set;
               fresh_in  = 1'b0;
            end
            OP_END: begin
               active_in = '0;
               fresh_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         fresh_ff  <= 1'b1;
      end else begin
         active_ff <= active_in;
         fresh_ff  <= fresh_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_op_ff == OP_END) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv && s1_op_ff == OP_END) begin
         rsp_accepted_ff <= res_accepted;
         rsp_status_ff   <= !start_defined_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_accept)
      else $error("item accepted during clearing pass");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff && clr_addr_ff == SYMBOL_BITS'(SYM_COUNT - 1) |=> !clr_busy_ff)
      else $error("clearing pass did not end");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_op_ff == OP_END |=> fresh_ff && active_ff == '0)
      else $error("end of string did not restart the set");

   a_hold_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> s1_op_ff == OP_END && rsp_valid_ff && rsp_stall)
      else $error("stage one held without a blocked result");

   a_error_not_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_accepted_ff && rsp_status_ff))
      else $error("accepted set together with error status");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import nfa_sa_pkg::*;

   localparam int NUM_PHASES      = 12;
   localparam int BEATS_PER_PHASE = 150;
   localparam int QUIET_LIMIT     = 2000;

   typedef struct packed {
      opcode_type           opcode;
      logic [SYMBOL_W-1:0]  symbol;
      logic [STATE_W-1:0]   from_state;
      logic [STATE_W-1:0]   to_state;
   } nfa_beat_type;

   typedef struct packed {
      logic accepted;
      logic status;
   } verdict_type;

   typedef struct packed {
      logic                 is_csr;
      nfa_beat_type         beat;
      logic                 typed;
      verdict_type          want;
      logic [STATE_W-1:0]   start;
      logic                 defined;
      state_set_type        mask;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [SYMBOL_W-1:0]   req_symbol = '0;
   logic [STATE_W-1:0]    req_from_state = '0;
   logic [STATE_W-1:0]    req_to_state = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic                  rsp_status;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // automaton tracker state
   bit [NUM_STATES-1:0] dest_rows [SYM_COUNT][NUM_STATES];
   state_set_type       active_states = '0;
   bit                  string_fresh = 1'b1;
   logic [STATE_W-1:0]  cfg_start = '0;
   logic                cfg_defined = 1'b0;
   state_set_type       cfg_accept = '0;

   verdict_type    pending_verdicts [$];
   script_row_type script [$];
   int             mismatches = 0;
   int             beats_sent = 0;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             rsp_stall_left = 0;
   int             quiet_cycles = 0;

   nfa_string_acceptor_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_symbol     (req_symbol),
      .req_from_state (req_from_state),
      .req_to_state   (req_to_state),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // advances the automaton by one beat; returns 1 when the beat yields a verdict
   function automatic bit track_automaton(input nfa_beat_type b, output verdict_type v);
      logic [SYMBOL_BITS-1:0] sym;
      state_set_type          cur;
      state_set_type          nxt;
      sym = b.symbol[SYMBOL_BITS-1:0];
      v = '0;
      if (string_fresh) begin
         if (cfg_defined && cfg_start < NUM_STATES)
            cur = state_set_type'(1) << cfg_start;
         else
            cur = '0;
      end else begin
         cur = active_states;
      end
      case (b.opcode)
         OP_ADD_TRANS: begin
            if (b.from_state < NUM_STATES && b.to_state < NUM_STATES)
               dest_rows[sym][b.from_state][b.to_state] = 1'b1;
            return 1'b0;
         end
         OP_SYMBOL: begin
            nxt = '0;
            for (int s = 0; s < NUM_STATES; s++)
               if (cur[s])
                  nxt |= dest_rows[sym][s];
            active_states = nxt;
            string_fresh = 1'b0;
            return 1'b0;
         end
         OP_END: begin
            v.status = !cfg_defined;
            v.accepted = cfg_defined && ((cur & cfg_accept) != '0);
            active_states = '0;
            string_fresh = 1'b1;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic nfa_beat_type mk_beat(input opcode_type op, input logic [7:0] sym,
                                            input logic [3:0] f, input logic [3:0] t);
      nfa_beat_type b;
      b.opcode = op;
      b.symbol = sym;
      b.from_state = f;
      b.to_state = t;
      return b;
   endfunction

   function automatic script_row_type beat_row(input opcode_type op, input logic [7:0] sym,
                                               input logic [3:0] f, input logic [3:0] t);
      script_row_type r;
      r = '0;
      r.beat = mk_beat(op, sym, f, t);
      return r;
   endfunction

   function automatic script_row_type verdict_row(input logic acc, input logic st);
      script_row_type r;
      r = beat_row(OP_END, 8'h5A, 4'd9, 4'd6);
      r.typed = 1'b1;
      r.want.accepted = acc;
      r.want.status = st;
      return r;
   endfunction

   function automatic script_row_type csr_row(input logic [3:0] st, input logic def,
                                              input logic [15:0] mask);
      script_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.start = st;
      r.defined = def;
      r.mask = mask;
      return r;
   endfunction

   task automatic send_beat(input nfa_beat_type b, input bit typed, input verdict_type want);
      verdict_type v;
      bit          has_verdict;
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= b.opcode;
      req_symbol <= b.symbol;
      req_from_state <= b.from_state;
      req_to_state <= b.to_state;
      do @(posedge clock); while (req_stall !== 1'b0);
      has_verdict = track_automaton(b, v);
      if (has_verdict)
         pending_verdicts.push_back(typed ? want : v);
      beats_sent++;
      @(negedge clock);
   endtask

   // registers are only touched once the pipeline has drained
   task automatic write_config(input logic [STATE_W-1:0] st,
                               input logic def,
                               input state_set_type mask);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_START_STATE;
      csr_wdata <= CSR_DATA_W'(st);
      @(negedge clock);
      csr_index <= CSR_START_DEFINED;
      csr_wdata <= CSR_DATA_W'(def);
      @(negedge clock);
      csr_index <= CSR_ACCEPT_MASK;
      csr_wdata <= CSR_DATA_W'(mask);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_start = st;
      cfg_defined = def;
      cfg_accept = mask;
   endtask

   // result side backpressure in short bursts
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left--;
      end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no verdict pending: accepted %b status %b",
                   rsp_accepted, rsp_status);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0b, got %0b", want.accepted, rsp_accepted);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0b, got %0b", want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      nfa_beat_type       b;
      script_row_type     row;
      logic [7:0]         letters [4];
      logic [3:0]         live [5];
      logic [3:0]         st;
      logic               def;
      logic [15:0]        mask;
      int                 len;
      int                 n_adds;

      script.push_back(verdict_row(1'b0, 1'b1));
      script.push_back(beat_row(OP_SYMBOL, 8'hFF, 4'd15, 4'd15));
      script.push_back(verdict_row(1'b0, 1'b1));
      script.push_back(csr_row(4'd0, 1'b1, 16'h0001));
      script.push_back(verdict_row(1'b1, 1'b0));  // empty string, start is final
      script.push_back(beat_row(OP_ADD_TRANS, 8'hFF, 4'd0, 4'd15));
      script.push_back(beat_row(OP_ADD_TRANS, 8'hFF, 4'd0, 4'd15));
      script.push_back(beat_row(OP_ADD_TRANS, 8'h00, 4'd15, 4'd0));
      script.push_back(beat_row(OP_ADD_TRANS, 8'h00, 4'd15, 4'd15));
      script.push_back(beat_row(OP_UNUSED, 8'h00, 4'd0, 4'd7));
      script.push_back(beat_row(OP_SYMBOL, 8'hFF, 4'd0, 4'd0));
      script.push_back(beat_row(OP_END, 8'h00, 4'd0, 4'd0));
      script.push_back(beat_row(OP_SYMBOL, 8'hFF, 4'd3, 4'd12));
      script.push_back(beat_row(OP_SYMBOL, 8'h00, 4'd12, 4'd3));
      script.push_back(beat_row(OP_END, 8'hFF, 4'd15, 4'd15));
      script.push_back(csr_row(4'd15, 1'b1, 16'h8000));
      script.push_back(beat_row(OP_SYMBOL, 8'h00, 4'd0, 4'd0));
      script.push_back(beat_row(OP_SYMBOL, 8'h00, 4'd0, 4'd0));
      script.push_back(beat_row(OP_END, 8'h00, 4'd0, 4'd0));
      // string left open across register writes
      script.push_back(beat_row(OP_SYMBOL, 8'h7F, 4'd0, 4'd0));
      script.push_back(csr_row(4'd0, 1'b0, 16'hFFFF));
      script.push_back(verdict_row(1'b0, 1'b1));
      script.push_back(csr_row(4'd0, 1'b1, 16'hFFFF));
      script.push_back(beat_row(OP_SYMBOL, 8'hFF, 4'd0, 4'd0));
      script.push_back(csr_row(4'd3, 1'b1, 16'h8000));
      script.push_back(beat_row(OP_END, 8'h00, 4'd0, 4'd0));
      script.push_back(beat_row(OP_END, 8'h00, 4'd0, 4'd0));
      // an unused opcode must not have added 0 -> 7 on symbol 0x00
      script.push_back(csr_row(4'd0, 1'b1, 16'h0080));
      script.push_back(beat_row(OP_SYMBOL, 8'h00, 4'd0, 4'd0));
      script.push_back(beat_row(OP_END, 8'h00, 4'd0, 4'd0));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 25;
      rsp_idle_pct = 25;
      foreach (script[i]) begin
         row = script[i];
         if (row.is_csr)
            write_config(row.start, row.defined, row.mask);
         else
            send_beat(row.beat, row.typed, row.want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         st = 4'($urandom_range(0, 15));
         def = ($urandom_range(0, 7) != 0);
         live[0] = st;
         for (int k = 1; k < 5; k++)
            live[k] = 4'($urandom_range(0, 15));
         mask = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                     : 16'd1 << live[$urandom_range(0, 4)];
         case (phase)
            0: begin
               st = 4'd0;
               def = 1'b1;
               mask = 16'hFFFF;
            end
            1: begin
               st = 4'd15;
               def = 1'b1;
               mask = 16'h0000;
            end
            2: def = 1'b0;
            default: ;
         endcase
         live[0] = st;
         if (phase >= NUM_PHASES - 2) begin
            // closing stretch at full rate on both sides
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: req_idle_pct = 0;
               1: req_idle_pct = 15;
               default: req_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 15;
               default: rsp_idle_pct = 40;
            endcase
         end
         write_config(st, def, mask);

         for (int k = 0; k < 4; k++)
            letters[k] = 8'($urandom_range(0, 255));
         n_adds = $urandom_range(6, 20);
         for (int k = 0; k < n_adds; k++) begin
            b = mk_beat(OP_ADD_TRANS, letters[$urandom_range(0, 3)],
                        live[$urandom_range(0, 4)],
                        $urandom_range(0, 4) == 0 ? 4'($urandom_range(0, 15))
                                                  : live[$urandom_range(0, 4)]);
            send_beat(b, 1'b0, '0);
         end

         while (beats_sent < 30 + (phase + 1) * BEATS_PER_PHASE) begin
            if ($urandom_range(99) < 80) begin
               len = $urandom_range(0, 8);
               for (int k = 0; k < len; k++) begin
                  b = mk_beat(OP_SYMBOL, letters[$urandom_range(0, 3)],
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                  send_beat(b, 1'b0, '0);
               end
               b = mk_beat(OP_END, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)));
               send_beat(b, 1'b0, '0);
            end else begin
               // stray beat: any opcode, any fields
               b = mk_beat(opcode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
               send_beat(b, 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
